FILE: sv/jfp_pkg.sv
// Package for the joystick frame parser: widths, protocol bytes, types and helpers.
`default_nettype none

package jfp_pkg;

	// Field widths of the beats
	localparam int BYTE_W = 8;
	localparam int VAL_W  = 15;
	localparam int MAG_W  = 14;

	// Defaults for the top-level parameters
	localparam int PAYLOAD_MAX_DEF  = 64;
	localparam int NUMBER_CHARS_DEF = 4;

	// Frame delimiters and number characters
	localparam logic [BYTE_W-1:0] START_BYTE = 8'h3C;
	localparam logic [BYTE_W-1:0] END_BYTE   = 8'h3E;
	localparam logic [BYTE_W-1:0] SEP_BYTE   = 8'h3B;
	localparam logic [BYTE_W-1:0] MINUS_BYTE = 8'h2D;
	localparam logic [BYTE_W-1:0] PLUS_BYTE  = 8'h2B;
	localparam logic [MAG_W-1:0]  MAG_MAX    = 14'd16383;

	// Field counter
	localparam int FIELD_W = 3;
	localparam logic [FIELD_W-1:0] FIELD_X    = 3'd0;
	localparam logic [FIELD_W-1:0] FIELD_Y    = 3'd1;
	localparam logic [FIELD_W-1:0] FIELD_BTN0 = 3'd2;
	localparam logic [FIELD_W-1:0] FIELD_BTN2 = 3'd4;
	localparam logic [FIELD_W-1:0] FIELD_LAST = 3'd7;
	localparam int NUM_BUTTONS = 3;

	// Number scanner phase
	typedef enum logic [1:0] {
		PH_SKIP,
		PH_DIGITS,
		PH_STOP
	} num_phase_t;

	function automatic logic is_space(input logic [BYTE_W-1:0] b);
		return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	function automatic logic is_digit(input logic [BYTE_W-1:0] b);
		return (b >= 8'h30 && b <= 8'h39);
	endfunction

endpackage

`default_nettype wire

FILE: sv/jfp_if.sv
// Valid/ready channel interfaces for received bytes and parsed joystick beats.
`default_nettype none

interface jfp_byte_if;
	import jfp_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface jfp_joy_if;
	import jfp_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    frame_end;
	logic                    frame_valid;
	logic signed [VAL_W-1:0] joy_x;
	logic signed [VAL_W-1:0] joy_y;
	logic [BYTE_W-1:0]       button_cross;
	logic [BYTE_W-1:0]       button_circle;
	logic [BYTE_W-1:0]       button_tri;

	modport source (
		output valid, output frame_end, output frame_valid, output joy_x, output joy_y,
		output button_cross, output button_circle, output button_tri, input ready
	);
	modport sink (
		input valid, input frame_end, input frame_valid, input joy_x, input joy_y,
		input button_cross, input button_circle, input button_tri, output ready
	);
endinterface

`default_nettype wire

FILE: sv/joystick_frame_parser.sv
// Joystick frame parser: byte-serial parsing of '<' X;Y;bx;bo;bt '>' command frames.
//
// rx  : one received byte per beat (valid/ready).
// joy : one result beat per accepted byte. frame_end marks the '>' that closed
//       a frame; frame_valid is set on that beat when X and Y were both nonzero.
//       joy_x, joy_y and the three button bytes always show the last committed frame.
// Result: a byte's beat is registered and shows on joy in the cycle after it is taken.
// Throughput: one byte per cycle while joy takes its beats; a byte's parsing is one pass
//       through scanner logic (one multiply-by-ten add) into state and result registers.
// Stall: the result register holds while joy.ready is low; rx.ready then drops
//       until the pending result is taken, so no beat is lost or repeated.
// Reset: arst_n clears the parser to "waiting for '<'" and all committed values
//       to zero; no result beat is pending after reset.
// Bytes outside a frame are dropped until '<'; payload bytes past PAYLOAD_MAX are
// ignored, but '>' still closes the frame.
`default_nettype none

module joystick_frame_parser #(
	parameter int PAYLOAD_MAX  = jfp_pkg::PAYLOAD_MAX_DEF,
	parameter int NUMBER_CHARS = jfp_pkg::NUMBER_CHARS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	jfp_byte_if.sink   rx,
	jfp_joy_if.source  joy
);
	import jfp_pkg::*;

	localparam int PW = $clog2(PAYLOAD_MAX + 1);
	localparam int CW = $clog2(NUMBER_CHARS + 1);
	localparam int MW = MAG_W + 4;

	typedef struct packed {
		logic [CW-1:0]    chars;
		num_phase_t       phase;
		logic             neg;
		logic [MAG_W-1:0] mag;
	} num_state_t;

	localparam num_state_t NUM_CLEAR = '{chars: '0, phase: PH_SKIP, neg: 1'b0, mag: '0};

	// One character of an atoi-style number scan
	function automatic num_state_t num_feed(input num_state_t p, input logic [BYTE_W-1:0] b);
		num_state_t r;
		logic [MW-1:0] m;
		r = p;
		m = ({{(MW-MAG_W){1'b0}}, p.mag} << 3) + ({{(MW-MAG_W){1'b0}}, p.mag} << 1)
			+ {{(MW-4){1'b0}}, b[3:0]};
		if (p.chars < CW'(NUMBER_CHARS)) begin
			r.chars = p.chars + 1'b1;
			case (p.phase)
				PH_SKIP: begin
					if (is_space(b)) begin
						r.phase = PH_SKIP;
					end else if (b == MINUS_BYTE) begin
						r.neg   = 1'b1;
						r.phase = PH_DIGITS;
					end else if (b == PLUS_BYTE) begin
						r.phase = PH_DIGITS;
					end else if (is_digit(b)) begin
						r.mag   = {{(MAG_W-4){1'b0}}, b[3:0]};
						r.phase = PH_DIGITS;
					end else begin
						r.phase = PH_STOP;
					end
				end
				PH_DIGITS: begin
					if (is_digit(b)) begin
						r.mag = (m > {{(MW-MAG_W){1'b0}}, MAG_MAX}) ? MAG_MAX : m[MAG_W-1:0];
					end else begin
						r.phase = PH_STOP;
					end
				end
				default: r = r;
			endcase
		end
		return r;
	endfunction

	function automatic logic [VAL_W-1:0] num_value(input num_state_t p);
		logic [VAL_W-1:0] m;
		m = {1'b0, p.mag};
		return p.neg ? (~m + 1'b1) : m;
	endfunction

	// Parser state
	logic                in_frame_q;
	logic [PW-1:0]       payload_cnt_q;
	logic [FIELD_W-1:0]  field_q;
	num_state_t          x_q, y_q;
	logic [BYTE_W-1:0]   pend_q [NUM_BUTTONS];
	// Committed values, driven straight onto the result beat
	logic [VAL_W-1:0]    commit_x_q, commit_y_q;
	logic [BYTE_W-1:0]   commit_btn_q [NUM_BUTTONS];
	// Result register
	logic                out_valid_q, out_end_q, out_fvalid_q;

	// Next-state signals
	logic                in_frame_d;
	logic [PW-1:0]       payload_cnt_d;
	logic [FIELD_W-1:0]  field_d, field_inc;
	num_state_t          x_d, y_d;
	logic [BYTE_W-1:0]   pend_d [NUM_BUTTONS];
	logic [VAL_W-1:0]    commit_x_d, commit_y_d;
	logic [BYTE_W-1:0]   commit_btn_d [NUM_BUTTONS];
	logic                end_d, fvalid_d;
	logic [1:0]          btn_idx;
	logic                take;
	logic [BYTE_W-1:0]   b;

	assign b        = rx.rx_byte;
	assign rx.ready = !out_valid_q || joy.ready;
	assign take     = rx.valid && rx.ready;

	// Field advance on separator, pending button slot of the new field
	assign field_inc = (b == SEP_BYTE && field_q < FIELD_LAST) ? field_q + 1'b1 : field_q;
	assign btn_idx   = 2'(field_inc - FIELD_BTN0);

	// Per-byte parse
	always_comb begin
		in_frame_d    = in_frame_q;
		payload_cnt_d = payload_cnt_q;
		field_d       = field_q;
		x_d           = x_q;
		y_d           = y_q;
		pend_d        = pend_q;
		commit_x_d    = commit_x_q;
		commit_y_d    = commit_y_q;
		commit_btn_d  = commit_btn_q;
		end_d         = 1'b0;
		fvalid_d      = 1'b0;
		if (!in_frame_q) begin
			if (b == START_BYTE) begin
				in_frame_d    = 1'b1;
				payload_cnt_d = '0;
				field_d       = FIELD_X;
				x_d           = NUM_CLEAR;
				y_d           = NUM_CLEAR;
				pend_d        = commit_btn_q;
			end
		end else if (b == END_BYTE) begin
			commit_x_d   = num_value(x_q);
			commit_y_d   = num_value(y_q);
			commit_btn_d = pend_q;
			end_d        = 1'b1;
			fvalid_d     = (commit_x_d != '0) && (commit_y_d != '0);
			in_frame_d   = 1'b0;
		end else if (payload_cnt_q < PW'(PAYLOAD_MAX)) begin
			payload_cnt_d = payload_cnt_q + 1'b1;
			if (field_q == FIELD_X) begin
				x_d = num_feed(x_q, b);
			end else if (field_q == FIELD_Y) begin
				y_d = num_feed(y_q, b);
			end
			field_d = field_inc;
			if (field_inc >= FIELD_BTN0 && field_inc <= FIELD_BTN2) begin
				pend_d[btn_idx] = b;
			end
		end
	end

	// State and committed values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q    <= 1'b0;
			payload_cnt_q <= '0;
			field_q       <= FIELD_X;
			x_q           <= NUM_CLEAR;
			y_q           <= NUM_CLEAR;
			pend_q        <= '{default: '0};
			commit_x_q    <= '0;
			commit_y_q    <= '0;
			commit_btn_q  <= '{default: '0};
		end else if (take) begin
			in_frame_q    <= in_frame_d;
			payload_cnt_q <= payload_cnt_d;
			field_q       <= field_d;
			x_q           <= x_d;
			y_q           <= y_d;
			pend_q        <= pend_d;
			commit_x_q    <= commit_x_d;
			commit_y_q    <= commit_y_d;
			commit_btn_q  <= commit_btn_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_end_q    <= 1'b0;
			out_fvalid_q <= 1'b0;
		end else if (take) begin
			out_valid_q  <= 1'b1;
			out_end_q    <= end_d;
			out_fvalid_q <= fvalid_d;
		end else if (joy.ready) begin
			out_valid_q  <= 1'b0;
		end
	end

	assign joy.valid         = out_valid_q;
	assign joy.frame_end     = out_end_q;
	assign joy.frame_valid   = out_fvalid_q;
	assign joy.joy_x         = commit_x_q;
	assign joy.joy_y         = commit_y_q;
	assign joy.button_cross  = commit_btn_q[0];
	assign joy.button_circle = commit_btn_q[1];
	assign joy.button_tri    = commit_btn_q[2];

`ifndef SYNTHESIS
	// A valid frame is only ever reported on a closing beat
	a_fvalid_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		joy.valid && joy.frame_valid |-> joy.frame_end)
		else $error("frame_valid without frame_end");

	// After a closing beat the parser waits for a new start byte
	a_end_leaves_frame: assert property (@(posedge clk) disable iff (!arst_n)
		joy.valid && joy.frame_end |-> !in_frame_q)
		else $error("parser still in frame after close");

	// Payload counter never passes its limit
	a_payload_bound: assert property (@(posedge clk) disable iff (!arst_n)
		payload_cnt_q <= PW'(PAYLOAD_MAX))
		else $error("payload counter overflow");

	// Outside a frame only the start byte opens one
	a_only_start_opens: assert property (@(posedge clk) disable iff (!arst_n)
		take && !in_frame_q && (b != START_BYTE) |=> !in_frame_q)
		else $error("frame opened by a non-start byte");

	// Committed values change only on a closing beat
	a_commit_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		take && !end_d |=> $stable(commit_x_q) && $stable(commit_y_q))
		else $error("committed axis changed outside a close");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/joystick_frame_parser_test.sv
// Self-checking testbench for the joystick frame parser: byte frames in, checked result beats out.
`timescale 1ns / 1ps

module joystick_frame_parser_test;
	import jfp_pkg::*;

	localparam int PAY_MAX      = PAYLOAD_MAX_DEF;
	localparam int NUM_CHARS    = NUMBER_CHARS_DEF;
	localparam int CLK_HALF     = 6;
	localparam int TIMEOUT_NS   = 5_000_000;
	localparam int RANDOM_BYTES = 960;
	localparam int HOLD_CYCLES  = 300;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef byte_t byte_q_t[$];

	// Number scanner state for one axis
	typedef struct {
		int unsigned seen;
		num_phase_t  ph;
		logic        neg;
		int unsigned mag;
	} scan_t;

	// One result beat as the parser should present it
	typedef struct {
		logic                                 fend;
		logic                                 fvalid;
		logic [VAL_W-1:0]                     x;
		logic [VAL_W-1:0]                     y;
		logic [NUM_BUTTONS-1:0][BYTE_W-1:0]   btn;
	} joy_beat_t;

	typedef enum int {RCV_FREE, RCV_RANDOM, RCV_PATTERN, RCV_SPARSE} rcv_mode_t;
	typedef enum int {FK_SHORT, FK_EXTRA_SEP, FK_LONG, FK_INNER_START, FK_UNCLOSED,
		FK_PLAIN} frame_kind_t;

	logic clk = 1'b0;
	logic arst_n;

	jfp_byte_if rx_ch ();
	jfp_joy_if  joy_ch ();

	joystick_frame_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.joy    (joy_ch)
	);

	// Parser state mirror
	logic                               parsing;
	int unsigned                        pay_cnt;
	logic [FIELD_W-1:0]                 field_idx;
	scan_t                              scan_x;
	scan_t                              scan_y;
	logic [NUM_BUTTONS-1:0][BYTE_W-1:0] pend_btn;
	logic [VAL_W-1:0]                   com_x;
	logic [VAL_W-1:0]                   com_y;
	logic [NUM_BUTTONS-1:0][BYTE_W-1:0] com_btn;

	joy_beat_t   expected_beats[$];
	int unsigned fail_count = 0;
	int unsigned live_bytes = 0;
	int unsigned burst_left = 0;
	logic        gaps_on    = 1'b0;
	rcv_mode_t   rcv_mode   = RCV_FREE;
	int unsigned hold_left  = 0;
	int unsigned stall_phase = 0;

	always begin
		#(CLK_HALF) clk = 1'b1;
		#(CLK_HALF) clk = 1'b0;
	end

	function automatic scan_t scan_cleared();
		scan_t s;
		s.seen = 0;
		s.ph   = PH_SKIP;
		s.neg  = 1'b0;
		s.mag  = 0;
		return s;
	endfunction

	// atoi-style scan of one character, limited to the first NUM_CHARS of the field
	function automatic void scan_feed(inout scan_t s, input byte_t b);
		logic        numeral;
		logic        blank;
		int unsigned acc;
		numeral = (b >= 8'h30) && (b <= 8'h39);
		blank   = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
		if (s.seen >= NUM_CHARS)
			return;
		s.seen++;
		case (s.ph)
		PH_SKIP: begin
			if (blank)
				;
			else if (b == MINUS_BYTE) begin
				s.neg = 1'b1;
				s.ph  = PH_DIGITS;
			end else if (b == PLUS_BYTE)
				s.ph = PH_DIGITS;
			else if (numeral) begin
				s.mag = b - 8'h30;
				s.ph  = PH_DIGITS;
			end else
				s.ph = PH_STOP;
		end
		PH_DIGITS: begin
			if (numeral) begin
				acc   = s.mag * 10 + (b - 8'h30);
				s.mag = (acc > MAG_MAX) ? MAG_MAX : acc;
			end else
				s.ph = PH_STOP;
		end
		default: ;
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] scan_value(input scan_t s);
		logic [VAL_W-1:0] m;
		m = VAL_W'(s.mag);
		return s.neg ? -m : m;
	endfunction

	function automatic void clear_mirror();
		parsing   = 1'b0;
		pay_cnt   = 0;
		field_idx = FIELD_X;
		scan_x    = scan_cleared();
		scan_y    = scan_cleared();
		pend_btn  = '0;
		com_x     = '0;
		com_y     = '0;
		com_btn   = '0;
	endfunction

	// Advance the mirror by one byte and return the beat it should produce
	function automatic joy_beat_t predict_byte(input byte_t b);
		joy_beat_t r;
		r.fend   = 1'b0;
		r.fvalid = 1'b0;
		if (!parsing) begin
			if (b == START_BYTE) begin
				parsing   = 1'b1;
				pay_cnt   = 0;
				field_idx = FIELD_X;
				scan_x    = scan_cleared();
				scan_y    = scan_cleared();
				pend_btn  = com_btn;
			end
		end else if (b == END_BYTE) begin
			com_x    = scan_value(scan_x);
			com_y    = scan_value(scan_y);
			com_btn  = pend_btn;
			r.fend   = 1'b1;
			r.fvalid = (com_x != '0) && (com_y != '0);
			parsing  = 1'b0;
		end else if (pay_cnt < PAY_MAX) begin
			pay_cnt++;
			if (field_idx == FIELD_X)
				scan_feed(scan_x, b);
			else if (field_idx == FIELD_Y)
				scan_feed(scan_y, b);
			// separator closes its field and seeds the next button byte
			if (b == SEP_BYTE && field_idx != FIELD_LAST)
				field_idx++;
			if (field_idx >= FIELD_BTN0 && field_idx <= FIELD_BTN2)
				pend_btn[field_idx - FIELD_BTN0] = b;
		end
		r.x   = com_x;
		r.y   = com_y;
		r.btn = com_btn;
		return r;
	endfunction

	// Send one byte beat; bursts of random length with random gaps when gaps_on
	task automatic send_byte(input byte_t b);
		if (gaps_on && burst_left == 0) begin
			rx_ch.valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		rx_ch.valid   = 1'b1;
		rx_ch.rx_byte = b;
		do begin
			@(posedge clk);
		end while (!rx_ch.ready);
		if (parsing || b == START_BYTE)
			live_bytes++;
		expected_beats.push_back(predict_byte(b));
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(byte_t'(s[i]));
	endtask

	task automatic wait_drained();
		rx_ch.valid = 1'b0;
		while (expected_beats.size() != 0)
			@(negedge clk);
	endtask

	// Random byte generators
	function automatic byte_t blank_byte();
		int unsigned r;
		r = $urandom_range(8, 13);
		return (r == 8) ? byte_t'(8'h20) : byte_t'(r);
	endfunction

	function automatic byte_t any_payload_byte();
		byte_t b;
		do
			b = byte_t'($urandom_range(0, 255));
		while (b == END_BYTE);
		return b;
	endfunction

	function automatic byte_t field_byte();
		byte_t b;
		do
			b = any_payload_byte();
		while (b == SEP_BYTE);
		return b;
	endfunction

	task automatic add_number(ref byte_q_t f);
		int unsigned n;
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
		repeat (n) f.push_back(blank_byte());
		case ($urandom_range(0, 5))
		0: f.push_back(MINUS_BYTE);
		1: f.push_back(PLUS_BYTE);
		default: ;
		endcase
		repeat ($urandom_range(0, 6)) f.push_back(byte_t'(8'h30 + $urandom_range(0, 9)));
		if ($urandom_range(0, 4) == 0)
			f.push_back(field_byte());
	endtask

	// Mostly well-formed frames with random content, some broken or oversized
	task automatic send_random_frame();
		byte_q_t     f;
		int unsigned k;
		int unsigned fields;
		frame_kind_t kind;
		k    = $urandom_range(0, 15);
		kind = (k < FK_PLAIN) ? frame_kind_t'(k) : FK_PLAIN;
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) f.push_back(byte_t'($urandom_range(0, 255)));
		f.push_back(START_BYTE);
		fields = (kind == FK_SHORT) ? $urandom_range(0, 4) : 5;
		for (int i = 0; i < fields; i++) begin
			if (i > 0)
				f.push_back(SEP_BYTE);
			if (i < 2)
				add_number(f);
			else
				repeat ($urandom_range(0, 3)) f.push_back(field_byte());
		end
		case (kind)
		FK_EXTRA_SEP:
			repeat ($urandom_range(1, 4)) begin
				f.push_back(SEP_BYTE);
				f.push_back(field_byte());
			end
		FK_LONG:        repeat ($urandom_range(60, 70)) f.push_back(any_payload_byte());
		FK_INNER_START: f.insert($urandom_range(1, f.size()), START_BYTE);
		default: ;
		endcase
		if (kind != FK_UNCLOSED)
			f.push_back(END_BYTE);
		foreach (f[i])
			send_byte(f[i]);
	endtask

	// Test: ordinary frames and field extremes
	task automatic test_basic_frames();
		send_text("<12;-34;a;b;c>");
		send_text("<9999;-999;");
		send_byte(8'hFF);
		send_byte(SEP_BYTE);
		send_byte(8'h00);
		send_byte(SEP_BYTE);
		send_byte(8'h80);
		send_byte(END_BYTE);
	endtask

	// Test: whitespace, signs, minus zero, no digits, number length cut
	task automatic test_number_forms();
		send_text("< \t+7;\015\n-0;x;y;z>");
		send_text("<12345;0042x;;;>");
		send_text("<ab;+-5;q;r;s>");
	endtask

	// Test: missing fields, extra separators, empty frame
	task automatic test_separator_cases();
		send_text("<3;4>");
		send_text("<;;;;;;;;;q>");
		send_text("<>");
	endtask

	// Test: bytes outside a frame, start byte inside a frame, payload overflow
	task automatic test_frame_edges();
		send_text(">a;5<1<2;3;<;a;b>");
		send_text("<5;6;");
		repeat (70) send_byte("z");
		send_text("k>");
	endtask

	// Test: random frames under changing sender and receiver timing
	task automatic test_random_traffic();
		int unsigned first;
		int unsigned frames;
		first  = live_bytes;
		frames = 0;
		while (live_bytes - first < RANDOM_BYTES) begin
			if (frames % 12 == 0) begin
				rcv_mode = rcv_mode_t'($urandom_range(0, 3));
				gaps_on  = ($urandom_range(0, 3) != 0);
			end
			send_random_frame();
			frames++;
		end
	endtask

	// Test: long receiver hold with the sender pushing, then a full drain pause
	task automatic test_backpressure();
		gaps_on   = 1'b0;
		rcv_mode  = RCV_FREE;
		hold_left = HOLD_CYCLES;
		repeat (4) send_random_frame();
		wait_drained();
		repeat (4) send_random_frame();
		wait_drained();
	endtask

	// Receiver ready: long hold first, else the current stall pattern
	always @(negedge clk) begin
		if (hold_left > 0) begin
			joy_ch.ready = 1'b0;
			hold_left--;
		end else begin
			case (rcv_mode)
			RCV_FREE:    joy_ch.ready = 1'b1;
			RCV_RANDOM:  joy_ch.ready = ($urandom_range(0, 2) != 0);
			RCV_PATTERN: joy_ch.ready = ((stall_phase % 5) < 3);
			default:     joy_ch.ready = ($urandom_range(0, 7) != 0);
			endcase
		end
		stall_phase++;
	end

	task automatic check_field(input string name, input logic [VAL_W-1:0] want,
			input logic [VAL_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			fail_count++;
		end
	endtask

	// Compare each accepted result beat with the oldest expectation
	always @(posedge clk) begin
		joy_beat_t want;
		if (arst_n && joy_ch.valid && joy_ch.ready) begin
			if (expected_beats.size() == 0) begin
				$error("result beat with no expectation pending");
				fail_count++;
			end else begin
				want = expected_beats.pop_front();
				check_field("frame_end", want.fend, joy_ch.frame_end);
				check_field("frame_valid", want.fvalid, joy_ch.frame_valid);
				check_field("joy_x", want.x, joy_ch.joy_x);
				check_field("joy_y", want.y, joy_ch.joy_y);
				check_field("button_cross", want.btn[0], joy_ch.button_cross);
				check_field("button_circle", want.btn[1], joy_ch.button_circle);
				check_field("button_tri", want.btn[2], joy_ch.button_tri);
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("joystick_frame_parser_test: FAIL");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		joy_ch.ready  = 1'b0;
		clear_mirror();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_basic_frames();
		test_number_forms();
		test_separator_cases();
		test_frame_edges();
		test_backpressure();
		test_random_traffic();

		// drain, then let the registered result show any stray beat
		rcv_mode = RCV_FREE;
		wait_drained();
		repeat (4) @(negedge clk);
		if (fail_count == 0)
			$display("joystick_frame_parser_test: PASS");
		else
			$display("joystick_frame_parser_test: FAIL");
		$finish;
	end

endmodule
